[rtl/assert_macros.svh]
// Assertion macros shared by the exit router RTL.
// Each expects clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define NVR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define NVR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nvr_pkg.sv]
// Types, exit reason codes and control bit positions for the exit router.
// No dependencies; used by every other RTL file but assert_macros.svh.
package nvr_pkg;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ReasonW  = 16;
  localparam int unsigned VecW     = 8;
  localparam int unsigned QualW    = 8;

  typedef enum logic [1:0] {
    DISP_REFLECT     = 2'd0,
    DISP_HOST        = 2'd1,
    DISP_UNSUPPORTED = 2'd2
  } disp_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPin       = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgPrimary   = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgSecondary = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgExcMask   = 8'd3;

  typedef struct packed {
    logic [CfgDataW-1:0] pin;
    logic [CfgDataW-1:0] primary;
    logic [CfgDataW-1:0] secondary;
    logic [CfgDataW-1:0] exc_mask;
  } ctrl_t;

  // Basic exit reasons
  localparam logic [ReasonW-1:0] ExitExcNmi   = 16'd0;
  localparam logic [ReasonW-1:0] ExitExtInt   = 16'd1;
  localparam logic [ReasonW-1:0] ExitCpuid    = 16'd10;
  localparam logic [ReasonW-1:0] ExitHlt      = 16'd12;
  localparam logic [ReasonW-1:0] ExitInvd     = 16'd13;
  localparam logic [ReasonW-1:0] ExitRdtsc    = 16'd16;
  localparam logic [ReasonW-1:0] ExitVmcall   = 16'd18;
  localparam logic [ReasonW-1:0] ExitVmclear  = 16'd19;
  localparam logic [ReasonW-1:0] ExitVmlaunch = 16'd20;
  localparam logic [ReasonW-1:0] ExitVmptrld  = 16'd21;
  localparam logic [ReasonW-1:0] ExitVmptrst  = 16'd22;
  localparam logic [ReasonW-1:0] ExitVmread   = 16'd23;
  localparam logic [ReasonW-1:0] ExitVmresume = 16'd24;
  localparam logic [ReasonW-1:0] ExitVmwrite  = 16'd25;
  localparam logic [ReasonW-1:0] ExitVmxoff   = 16'd26;
  localparam logic [ReasonW-1:0] ExitVmxon    = 16'd27;
  localparam logic [ReasonW-1:0] ExitCrAccess = 16'd28;
  localparam logic [ReasonW-1:0] ExitMovDr    = 16'd29;
  localparam logic [ReasonW-1:0] ExitIo       = 16'd30;
  localparam logic [ReasonW-1:0] ExitRdmsr    = 16'd31;
  localparam logic [ReasonW-1:0] ExitWrmsr    = 16'd32;
  localparam logic [ReasonW-1:0] ExitMwait    = 16'd36;
  localparam logic [ReasonW-1:0] ExitMonitor  = 16'd39;
  localparam logic [ReasonW-1:0] ExitPause    = 16'd40;
  localparam logic [ReasonW-1:0] ExitInvept   = 16'd50;
  localparam logic [ReasonW-1:0] ExitInvvpid  = 16'd53;
  localparam logic [ReasonW-1:0] ExitWbinvd   = 16'd54;
  localparam logic [ReasonW-1:0] ExitXsetbv   = 16'd55;
  localparam logic [ReasonW-1:0] ExitRdrand   = 16'd57;
  localparam logic [ReasonW-1:0] ExitInvpcid  = 16'd58;
  localparam logic [ReasonW-1:0] ExitRdseed   = 16'd61;
  localparam logic [ReasonW-1:0] ExitXsaves   = 16'd63;
  localparam logic [ReasonW-1:0] ExitXrstors  = 16'd64;
  localparam logic [ReasonW-1:0] ExitUmwait   = 16'd67;
  localparam logic [ReasonW-1:0] ExitTpause   = 16'd68;

  localparam logic [VecW-1:0] VecNmi = 8'd2;
  localparam logic [3:0] CrNum3 = 4'd3;
  localparam logic [3:0] CrNum8 = 4'd8;
  localparam int unsigned QualStoreBit = 4;

  // Pin-based control bits
  localparam int unsigned PinExtIntBit = 0;
  localparam int unsigned PinNmiBit    = 3;

  // Primary control bits
  localparam int unsigned PriHltBit     = 7;
  localparam int unsigned PriInvlpgBit  = 9;
  localparam int unsigned PriMwaitBit   = 10;
  localparam int unsigned PriRdtscBit   = 12;
  localparam int unsigned PriCr3LdBit   = 15;
  localparam int unsigned PriCr3StBit   = 16;
  localparam int unsigned PriCr8LdBit   = 19;
  localparam int unsigned PriCr8StBit   = 20;
  localparam int unsigned PriMovDrBit   = 23;
  localparam int unsigned PriUncondIoBit = 24;
  localparam int unsigned PriIoBmpBit   = 25;
  localparam int unsigned PriMsrBmpBit  = 28;
  localparam int unsigned PriMonitorBit = 29;
  localparam int unsigned PriPauseBit   = 30;

  // Secondary control bits
  localparam int unsigned SecWbinvdBit  = 6;
  localparam int unsigned SecRdrandBit  = 11;
  localparam int unsigned SecInvpcidBit = 12;
  localparam int unsigned SecRdseedBit  = 16;
  localparam int unsigned SecXsavesBit  = 20;
  localparam int unsigned SecUwaitBit   = 26;

endpackage

[rtl/nvr_ifs.sv]
// Valid/ready channel interfaces for the exit router: input, result, config.
// Depends on nvr_pkg for field widths.
interface nvr_in_if;
  logic                         valid;
  logic                         ready;
  logic [nvr_pkg::ReasonW-1:0]  basic_reason;
  logic [nvr_pkg::VecW-1:0]     vector_number;
  logic [nvr_pkg::QualW-1:0]    cr_qual_low;
  logic                         io_bit;
  logic                         msr_bit;

  modport source (output valid, basic_reason, vector_number, cr_qual_low, io_bit, msr_bit,
                  input ready);
  modport sink (input valid, basic_reason, vector_number, cr_qual_low, io_bit, msr_bit,
                output ready);
endinterface

interface nvr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] disposition;

  modport source (output valid, disposition, input ready);
  modport sink (input valid, disposition, output ready);
endinterface

interface nvr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [nvr_pkg::CfgIdxW-1:0]  index;
  logic [nvr_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/nvr_cfg_regs.sv]
// Control word registers of the exit router, written through the config channel.
// Depends on nvr_pkg, nvr_ifs and assert_macros.svh.
`include "assert_macros.svh"

module nvr_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  nvr_cfg_if.sink        cfg_ch,
  output nvr_pkg::ctrl_t ctrl
);

  nvr_pkg::ctrl_t ctrl_r;
  nvr_pkg::ctrl_t ctrl_nxt;
  logic           wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    ctrl_nxt = ctrl_r;
    if (wr_en) begin
      unique case (cfg_ch.index)
        nvr_pkg::CfgPin:       ctrl_nxt.pin       = cfg_ch.data;
        nvr_pkg::CfgPrimary:   ctrl_nxt.primary   = cfg_ch.data;
        nvr_pkg::CfgSecondary: ctrl_nxt.secondary = cfg_ch.data;
        nvr_pkg::CfgExcMask:   ctrl_nxt.exc_mask  = cfg_ch.data;
        default:               ctrl_nxt = ctrl_r;   // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
  end

  assign ctrl = ctrl_r;

  `NVR_ASSERT_NEXT(a_exc_mask_wr, wr_en && cfg_ch.index == nvr_pkg::CfgExcMask,
                   ctrl_r.exc_mask == $past(cfg_ch.data), "exception mask write lost")
  `NVR_ASSERT_NEXT(a_no_wr_hold, !wr_en, $stable(ctrl_r), "control words changed without write")

endmodule

[rtl/nvr_classify.sv]
// Exit disposition decode: reason, vector and qualification against control words.
// Depends on nvr_pkg.
module nvr_classify (
  input  logic [nvr_pkg::ReasonW-1:0] basic_reason,
  input  logic [nvr_pkg::VecW-1:0]    vector_number,
  input  logic [nvr_pkg::QualW-1:0]   cr_qual_low,
  input  logic                        io_bit,
  input  logic                        msr_bit,
  input  nvr_pkg::ctrl_t              ctrl,
  output nvr_pkg::disp_t              disposition
);

  logic [3:0] cr_num;
  logic       cr_store;
  logic       vec_in_mask;

  assign cr_num      = cr_qual_low[3:0];
  assign cr_store    = cr_qual_low[nvr_pkg::QualStoreBit];
  assign vec_in_mask = (vector_number[7:5] == 3'b000) && ctrl.exc_mask[vector_number[4:0]];

  function automatic nvr_pkg::disp_t pick(input logic wants);
    pick = wants ? nvr_pkg::DISP_REFLECT : nvr_pkg::DISP_HOST;
  endfunction

  always_comb begin
    unique case (basic_reason)
      nvr_pkg::ExitVmcall, nvr_pkg::ExitVmclear, nvr_pkg::ExitVmlaunch,
      nvr_pkg::ExitVmptrld, nvr_pkg::ExitVmptrst, nvr_pkg::ExitVmread,
      nvr_pkg::ExitVmresume, nvr_pkg::ExitVmwrite, nvr_pkg::ExitVmxoff,
      nvr_pkg::ExitVmxon, nvr_pkg::ExitInvept, nvr_pkg::ExitInvvpid,
      nvr_pkg::ExitCpuid, nvr_pkg::ExitInvd, nvr_pkg::ExitXsetbv:
        disposition = nvr_pkg::DISP_HOST;
      nvr_pkg::ExitExcNmi: begin
        if (vector_number == nvr_pkg::VecNmi) begin
          disposition = pick(ctrl.pin[nvr_pkg::PinNmiBit]);
        end else begin
          disposition = pick(vec_in_mask);
        end
      end
      nvr_pkg::ExitExtInt: disposition = pick(ctrl.pin[nvr_pkg::PinExtIntBit]);
      nvr_pkg::ExitHlt:    disposition = pick(ctrl.primary[nvr_pkg::PriHltBit]);
      nvr_pkg::ExitRdtsc:  disposition = pick(ctrl.primary[nvr_pkg::PriRdtscBit]);
      nvr_pkg::ExitMovDr:  disposition = pick(ctrl.primary[nvr_pkg::PriMovDrBit]);
      nvr_pkg::ExitCrAccess: begin
        // only CR3 and CR8 have exiting controls; other CRs stay with the host
        if (cr_num == nvr_pkg::CrNum3) begin
          disposition = pick(cr_store ? ctrl.primary[nvr_pkg::PriCr3StBit]
                                      : ctrl.primary[nvr_pkg::PriCr3LdBit]);
        end else if (cr_num == nvr_pkg::CrNum8) begin
          disposition = pick(cr_store ? ctrl.primary[nvr_pkg::PriCr8StBit]
                                      : ctrl.primary[nvr_pkg::PriCr8LdBit]);
        end else begin
          disposition = nvr_pkg::DISP_HOST;
        end
      end
      nvr_pkg::ExitIo: begin
        if (ctrl.primary[nvr_pkg::PriUncondIoBit]) begin
          disposition = nvr_pkg::DISP_REFLECT;
        end else if (ctrl.primary[nvr_pkg::PriIoBmpBit]) begin
          disposition = pick(io_bit);
        end else begin
          disposition = nvr_pkg::DISP_HOST;
        end
      end
      nvr_pkg::ExitRdmsr, nvr_pkg::ExitWrmsr:
        disposition = pick(ctrl.primary[nvr_pkg::PriMsrBmpBit] && msr_bit);
      nvr_pkg::ExitMwait:   disposition = pick(ctrl.primary[nvr_pkg::PriMwaitBit]);
      nvr_pkg::ExitMonitor: disposition = pick(ctrl.primary[nvr_pkg::PriMonitorBit]);
      nvr_pkg::ExitPause:   disposition = pick(ctrl.primary[nvr_pkg::PriPauseBit]);
      nvr_pkg::ExitWbinvd:  disposition = pick(ctrl.secondary[nvr_pkg::SecWbinvdBit]);
      nvr_pkg::ExitRdrand:  disposition = pick(ctrl.secondary[nvr_pkg::SecRdrandBit]);
      nvr_pkg::ExitInvpcid:
        disposition = pick(ctrl.secondary[nvr_pkg::SecInvpcidBit] &&
                           ctrl.primary[nvr_pkg::PriInvlpgBit]);
      nvr_pkg::ExitRdseed:  disposition = pick(ctrl.secondary[nvr_pkg::SecRdseedBit]);
      nvr_pkg::ExitXsaves, nvr_pkg::ExitXrstors:
        disposition = pick(ctrl.secondary[nvr_pkg::SecXsavesBit]);
      nvr_pkg::ExitUmwait, nvr_pkg::ExitTpause:
        disposition = pick(ctrl.secondary[nvr_pkg::SecUwaitBit] &&
                           ctrl.primary[nvr_pkg::PriRdtscBit]);
      default: disposition = nvr_pkg::DISP_UNSUPPORTED;
    endcase
  end

endmodule

[rtl/nested_vm_exit_router_top.sv]
// Nested VM exit router. Each exit word is captured in an input register, decoded
// against the guest hypervisor's control words and held in a result register, so an
// exit passes from one to the other; one word is accepted each cycle unless the output
// stalls; the decode between the two registers sets the clock. A stalled result holds
// the pipe, and in_ch.ready falls only when both registers are full and out_ch.ready
// is low. Configuration writes are always taken and apply to every word not yet
// decoded, including one held in the input register, so write only with the pipe empty.
// Depends on nvr_pkg, nvr_ifs, nvr_cfg_regs, nvr_classify and assert_macros.svh.
`include "assert_macros.svh"

module nested_vm_exit_router_top (
  input  logic    clk,
  input  logic    rst_n,
  nvr_in_if.sink  in_ch,
  nvr_out_if.source out_ch,
  nvr_cfg_if.sink cfg_ch
);

  nvr_pkg::ctrl_t ctrl;
  nvr_pkg::disp_t disp_dec;

  logic                        s1_valid_r;
  logic [nvr_pkg::ReasonW-1:0] s1_reason_r;
  logic [nvr_pkg::VecW-1:0]    s1_vec_r;
  logic [nvr_pkg::QualW-1:0]   s1_qual_r;
  logic                        s1_iob_r;
  logic                        s1_msrb_r;

  logic           out_valid_r;
  nvr_pkg::disp_t out_disp_r;

  logic out_adv;
  logic s1_adv;
  logic in_take;

  nvr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .ctrl   (ctrl)
  );

  nvr_classify u_dec (
    .basic_reason  (s1_reason_r),
    .vector_number (s1_vec_r),
    .cr_qual_low   (s1_qual_r),
    .io_bit        (s1_iob_r),
    .msr_bit       (s1_msrb_r),
    .ctrl          (ctrl),
    .disposition   (disp_dec)
  );

  // result register can load when empty or being drained
  assign out_adv = !out_valid_r || out_ch.ready;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign in_take = in_ch.valid && s1_adv;

  assign in_ch.ready        = s1_adv;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.disposition = out_disp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_reason_r <= in_ch.basic_reason;
      s1_vec_r    <= in_ch.vector_number;
      s1_qual_r   <= in_ch.cr_qual_low;
      s1_iob_r    <= in_ch.io_bit;
      s1_msrb_r   <= in_ch.msr_bit;
    end
    if (out_adv && s1_valid_r) begin
      out_disp_r <= disp_dec;
    end
  end

  `NVR_ASSERT_NEXT(a_take_fills_s1, in_take, s1_valid_r, "accepted word not captured")
  `NVR_ASSERT_NEXT(a_s1_moves_out, s1_valid_r && out_adv, out_valid_r, "decoded word lost")
  `NVR_ASSERT(a_disp_legal, out_valid_r,
              out_disp_r == nvr_pkg::DISP_REFLECT || out_disp_r == nvr_pkg::DISP_HOST ||
              out_disp_r == nvr_pkg::DISP_UNSUPPORTED, "illegal disposition code")
  `NVR_ASSERT(a_full_stall, s1_valid_r && out_valid_r && !out_ch.ready, !in_ch.ready,
              "input taken while pipe full")

endmodule

[dv/tb_nested_vm_exit_router_top.sv]
// Self-checking testbench for nested_vm_exit_router_top: exit words in, dispositions out.
// A local routing predictor mirrors the control words written through the config channel.
// Depends on nvr_pkg, nvr_ifs and the router RTL.
module tb_nested_vm_exit_router_top;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned IdlePct     = 36;

  typedef logic [nvr_pkg::ReasonW-1:0]  reason_t;
  typedef logic [nvr_pkg::VecW-1:0]     vec_t;
  typedef logic [nvr_pkg::QualW-1:0]    qual_t;
  typedef logic [nvr_pkg::CfgDataW-1:0] word_t;

  typedef struct {
    reason_t reason;
    vec_t    vec;
    qual_t   qual;
    logic    iob;
    logic    msrb;
  } exit_word_t;

  logic clk;
  logic rst_n;

  nvr_in_if  in_if ();
  nvr_out_if out_if ();
  nvr_cfg_if cfg_if ();

  nested_vm_exit_router_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  nvr_pkg::ctrl_t ctrl_shadow;
  nvr_pkg::disp_t pending_disp[$];
  nvr_pkg::disp_t want_disp;
  int unsigned    err_cnt = 0;
  int unsigned    cycle_cnt = 0;
  bit             gaps_on;
  int unsigned    hold_cycles;
  int unsigned    hold_tag;
  int unsigned    hold_seen = 0;
  int unsigned    hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic nvr_pkg::disp_t want(logic wanted);
    return wanted ? nvr_pkg::DISP_REFLECT : nvr_pkg::DISP_HOST;
  endfunction

  // Expected disposition of one exit word under the current control words
  function automatic nvr_pkg::disp_t route_exit(exit_word_t w);
    word_t          p;
    word_t          s;
    logic [3:0]     cr;
    logic           store;
    nvr_pkg::disp_t d;
    p = ctrl_shadow.primary;
    s = ctrl_shadow.secondary;
    cr = w.qual[3:0];
    store = w.qual[nvr_pkg::QualStoreBit];
    d = nvr_pkg::DISP_UNSUPPORTED;
    case (w.reason)
      nvr_pkg::ExitVmcall, nvr_pkg::ExitVmclear, nvr_pkg::ExitVmlaunch,
      nvr_pkg::ExitVmptrld, nvr_pkg::ExitVmptrst, nvr_pkg::ExitVmread,
      nvr_pkg::ExitVmresume, nvr_pkg::ExitVmwrite, nvr_pkg::ExitVmxoff,
      nvr_pkg::ExitVmxon, nvr_pkg::ExitInvept, nvr_pkg::ExitInvvpid,
      nvr_pkg::ExitCpuid, nvr_pkg::ExitInvd, nvr_pkg::ExitXsetbv: d = nvr_pkg::DISP_HOST;
      nvr_pkg::ExitExcNmi: begin
        if (w.vec == nvr_pkg::VecNmi) d = want(ctrl_shadow.pin[nvr_pkg::PinNmiBit]);
        else if (w.vec < 8'd32 && ctrl_shadow.exc_mask[w.vec[4:0]]) d = nvr_pkg::DISP_REFLECT;
        else d = nvr_pkg::DISP_HOST;
      end
      nvr_pkg::ExitExtInt: d = want(ctrl_shadow.pin[nvr_pkg::PinExtIntBit]);
      nvr_pkg::ExitHlt:    d = want(p[nvr_pkg::PriHltBit]);
      nvr_pkg::ExitRdtsc:  d = want(p[nvr_pkg::PriRdtscBit]);
      nvr_pkg::ExitMovDr:  d = want(p[nvr_pkg::PriMovDrBit]);
      nvr_pkg::ExitCrAccess: begin
        if (cr == nvr_pkg::CrNum3)
          d = want(store ? p[nvr_pkg::PriCr3StBit] : p[nvr_pkg::PriCr3LdBit]);
        else if (cr == nvr_pkg::CrNum8)
          d = want(store ? p[nvr_pkg::PriCr8StBit] : p[nvr_pkg::PriCr8LdBit]);
        else d = nvr_pkg::DISP_HOST;
      end
      nvr_pkg::ExitIo: begin
        if (p[nvr_pkg::PriUncondIoBit]) d = nvr_pkg::DISP_REFLECT;
        else if (p[nvr_pkg::PriIoBmpBit]) d = want(w.iob);
        else d = nvr_pkg::DISP_HOST;
      end
      nvr_pkg::ExitRdmsr, nvr_pkg::ExitWrmsr:
        d = p[nvr_pkg::PriMsrBmpBit] ? want(w.msrb) : nvr_pkg::DISP_HOST;
      nvr_pkg::ExitMwait:   d = want(p[nvr_pkg::PriMwaitBit]);
      nvr_pkg::ExitMonitor: d = want(p[nvr_pkg::PriMonitorBit]);
      nvr_pkg::ExitPause:   d = want(p[nvr_pkg::PriPauseBit]);
      nvr_pkg::ExitWbinvd:  d = want(s[nvr_pkg::SecWbinvdBit]);
      nvr_pkg::ExitRdrand:  d = want(s[nvr_pkg::SecRdrandBit]);
      nvr_pkg::ExitInvpcid: d = want(s[nvr_pkg::SecInvpcidBit] && p[nvr_pkg::PriInvlpgBit]);
      nvr_pkg::ExitRdseed:  d = want(s[nvr_pkg::SecRdseedBit]);
      nvr_pkg::ExitXsaves, nvr_pkg::ExitXrstors: d = want(s[nvr_pkg::SecXsavesBit]);
      nvr_pkg::ExitUmwait, nvr_pkg::ExitTpause:
        d = want(s[nvr_pkg::SecUwaitBit] && p[nvr_pkg::PriRdtscBit]);
      default: d = nvr_pkg::DISP_UNSUPPORTED;
    endcase
    return d;
  endfunction

  function automatic exit_word_t make_exit(reason_t reason, vec_t vec, qual_t qual,
                                           logic iob, logic msrb);
    exit_word_t w;
    w.reason = reason;
    w.vec = vec;
    w.qual = qual;
    w.iob = iob;
    w.msrb = msrb;
    return w;
  endfunction

  function automatic exit_word_t random_exit();
    exit_word_t w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) w.reason = reason_t'($urandom_range(70));
    else if (pick < 90) w.reason = nvr_pkg::ExitCrAccess;
    else w.reason = reason_t'($urandom);
    pick = $urandom_range(3);
    if (pick == 0) w.vec = nvr_pkg::VecNmi;
    else if (pick == 1) w.vec = vec_t'($urandom_range(31));
    else w.vec = vec_t'($urandom);
    if ($urandom_range(1)) begin
      w.qual = qual_t'($urandom);
    end else begin
      w.qual[7:5] = 3'($urandom);
      w.qual[nvr_pkg::QualStoreBit] = 1'($urandom);
      w.qual[3:0] = $urandom_range(1) ? nvr_pkg::CrNum3 : nvr_pkg::CrNum8;
    end
    w.iob = 1'($urandom);
    w.msrb = 1'($urandom);
    return w;
  endfunction

  function automatic word_t random_ctrl_word();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_tag != hold_seen) begin
        hold_left = hold_cycles;
        hold_seen = hold_tag;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (gaps_on && $urandom_range(99) < IdlePct) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_disp.size() == 0) begin
        $error("unexpected result word: disposition %0d", out_if.disposition);
        err_cnt++;
      end else begin
        want_disp = pending_disp.pop_front();
        if (out_if.disposition !== want_disp) begin
          $error("disposition mismatch: expected %0d actual %0d", want_disp,
                 out_if.disposition);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_nested_vm_exit_router_top NOT OK");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_exit(exit_word_t w);
    while (gaps_on && $urandom_range(99) < IdlePct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.basic_reason <= w.reason;
    in_if.vector_number <= w.vec;
    in_if.cr_qual_low <= w.qual;
    in_if.io_bit <= w.iob;
    in_if.msr_bit <= w.msrb;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_disp.push_back(route_exit(w));
    @(negedge clk);
  endtask

  task automatic wait_results();
    in_if.valid <= 1'b0;
    while (pending_disp.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [nvr_pkg::CfgIdxW-1:0] idx, word_t data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      nvr_pkg::CfgPin:       ctrl_shadow.pin = data;
      nvr_pkg::CfgPrimary:   ctrl_shadow.primary = data;
      nvr_pkg::CfgSecondary: ctrl_shadow.secondary = data;
      nvr_pkg::CfgExcMask:   ctrl_shadow.exc_mask = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_ctrl(word_t pin, word_t pri, word_t sec, word_t exc);
    write_reg(nvr_pkg::CfgPin, pin);
    write_reg(nvr_pkg::CfgPrimary, pri);
    write_reg(nvr_pkg::CfgSecondary, sec);
    write_reg(nvr_pkg::CfgExcMask, exc);
  endtask

  task automatic test_directed();
    gaps_on = 1'b1;
    program_ctrl('1, '1, '1, '1);
    send_exit(make_exit(nvr_pkg::ExitExcNmi, nvr_pkg::VecNmi, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitExcNmi, 8'd0, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitExcNmi, 8'd31, 8'h00, 1'b0, 1'b0));
    // vectors past the bitmap go to the host
    send_exit(make_exit(nvr_pkg::ExitExcNmi, 8'd32, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitExcNmi, 8'hFF, 8'hFF, 1'b1, 1'b1));
    send_exit(make_exit(nvr_pkg::ExitExtInt, 8'd0, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitVmcall, 8'd0, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitInvept, 8'd0, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitCpuid, 8'd0, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitCrAccess, 8'd0, 8'h03, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitCrAccess, 8'd0, 8'h18, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitCrAccess, 8'd0, 8'h00, 1'b0, 1'b0));
    // upper qualification bits must not disturb the CR decode
    send_exit(make_exit(nvr_pkg::ExitCrAccess, 8'd0, 8'hF3, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitIo, 8'd0, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitRdmsr, 8'd0, 8'h00, 1'b0, 1'b1));
    send_exit(make_exit(nvr_pkg::ExitInvpcid, 8'd0, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitUmwait, 8'd0, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(16'd2, 8'd0, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(16'd33, 8'd0, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    wait_results();
    // bitmaps on, unconditional I/O and user wait off
    program_ctrl('0, (32'd1 << nvr_pkg::PriIoBmpBit) | (32'd1 << nvr_pkg::PriMsrBmpBit) |
                 (32'd1 << nvr_pkg::PriRdtscBit), '0, '0);
    send_exit(make_exit(nvr_pkg::ExitIo, 8'd0, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitIo, 8'd0, 8'h00, 1'b1, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitWrmsr, 8'd0, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitTpause, 8'd0, 8'h00, 1'b0, 1'b0));
    send_exit(make_exit(nvr_pkg::ExitExcNmi, nvr_pkg::VecNmi, 8'h00, 1'b0, 1'b0));
    wait_results();
  endtask

  task automatic test_random_phases();
    gaps_on = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      program_ctrl(random_ctrl_word(), random_ctrl_word(), random_ctrl_word(),
                   random_ctrl_word());
      repeat (60) send_exit(random_exit());
      wait_results();
    end
  endtask

  task automatic test_back_pressure();
    gaps_on = 1'b1;
    program_ctrl(word_t'($urandom), word_t'($urandom), word_t'($urandom),
                 word_t'($urandom));
    // hold the result side long enough to fill the pipe
    hold_cycles = 200;
    hold_tag++;
    repeat (30) send_exit(random_exit());
    // pause until every result is back, then resume
    in_if.valid <= 1'b0;
    while (pending_disp.size() != 0) @(negedge clk);
    @(negedge clk);
    repeat (30) send_exit(random_exit());
    wait_results();
  endtask

  task automatic test_no_gaps();
    gaps_on = 1'b0;
    program_ctrl('1, word_t'($urandom), '1, word_t'($urandom));
    repeat (120) send_exit(random_exit());
    wait_results();
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.basic_reason = '0;
    in_if.vector_number = '0;
    in_if.cr_qual_low = '0;
    in_if.io_bit = 1'b0;
    in_if.msr_bit = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    ctrl_shadow = '0;
    gaps_on = 1'b1;
    hold_cycles = 0;
    hold_tag = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_phases();
    test_back_pressure();
    test_no_gaps();
    test_random_phases();

    wait_results();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && pending_disp.size() == 0) begin
      $display("tb_nested_vm_exit_router_top OK");
    end else begin
      $display("tb_nested_vm_exit_router_top NOT OK");
    end
    $finish;
  end

endmodule

[nested_vm_exit_router_top.f]
+incdir+rtl
rtl/nvr_pkg.sv
rtl/nvr_ifs.sv
rtl/nvr_cfg_regs.sv
rtl/nvr_classify.sv
rtl/nested_vm_exit_router_top.sv
dv/tb_nested_vm_exit_router_top.sv
